/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on i_clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/ietp_pkg.sv */
// ----------------------------------------------------------------------------
// ietp_pkg
// Widths, codes and types shared by the element parser and its channels.
// ----------------------------------------------------------------------------
package ietp_pkg;

    localparam int LENGTH_BITS = 12;
    localparam int BYTE_W      = 8;
    localparam int MLEN_W      = 12;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_RELAY_CODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_CODE  = 1'd1;

    localparam logic [BYTE_W-1:0] RELAY_CODE_RST = 8'd255;
    localparam logic [BYTE_W-1:0] USER_CODE_RST  = 8'd6;

    localparam logic [1:0] PH_TYPE  = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    localparam logic [1:0] TGT_NONE  = 2'd0;
    localparam logic [1:0] TGT_RELAY = 2'd1;
    localparam logic [1:0] TGT_USER  = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERRUN  = 2'd1;
    localparam logic [1:0] ERR_BOUNDARY = 2'd2;

    localparam logic FIELD_RELAY = 1'b0;
    localparam logic FIELD_USER  = 1'b1;

    typedef struct packed {
        logic              start_of_message;
        logic              write_valid;
        logic              field_select;
        logic [BYTE_W-1:0] field_offset;
        logic [BYTE_W-1:0] field_data;
        logic              end_of_message;
        logic [1:0]        parse_status;
    } t_result;

endpackage

/* hdl/ietp_in_if.sv */
// ----------------------------------------------------------------------------
// ietp_in_if
// Byte channel into the element parser: one message byte per beat.
// ----------------------------------------------------------------------------
interface ietp_in_if import ietp_pkg::*; ;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic [MLEN_W-1:0] message_length;

    modport source (output valid, output data_byte, output first_byte,
                    output message_length, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input message_length, output ready);

endinterface

/* hdl/ietp_out_if.sv */
// ----------------------------------------------------------------------------
// ietp_out_if
// Result channel out of the element parser: one result beat per byte, carrying a field write when write_valid is set.
// ----------------------------------------------------------------------------
interface ietp_out_if import ietp_pkg::*; ;

    logic              valid;
    logic              ready;
    logic              start_of_message;
    logic              write_valid;
    logic              field_select;
    logic [BYTE_W-1:0] field_offset;
    logic [BYTE_W-1:0] field_data;
    logic              end_of_message;
    logic [1:0]        parse_status;

    modport source (output valid, output start_of_message, output write_valid,
                    output field_select, output field_offset, output field_data,
                    output end_of_message, output parse_status, input ready);
    modport sink   (input valid, input start_of_message, input write_valid,
                    input field_select, input field_offset, input field_data,
                    input end_of_message, input parse_status, output ready);

endinterface

/* hdl/information_element_tlv_parser_unit.sv */
// ----------------------------------------------------------------------------
// information_element_tlv_parser_unit
// Walks type-length-value elements of a message byte by byte and issues field
// writes for the value bytes of the two configured element types.
// ----------------------------------------------------------------------------
// One byte is taken every clock cycle and its result beat appears in the next
// cycle from a single output register; the input is stalled only while that
// register holds a beat the consumer has not taken. The first byte of a
// message carries its length; status (ok, overrun, stray trailing byte) is
// reported on the last byte. Type codes must be written through the
// configuration port while no message is in flight; the block does not enforce it.
`include "assert_macros.svh"

module information_element_tlv_parser_unit import ietp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    ietp_in_if.sink              i_in,
    ietp_out_if.source           o_out
);

    logic [BYTE_W-1:0]      r_relay_code;
    logic [BYTE_W-1:0]      r_user_code;
    logic [1:0]             r_phase,  n_phase;
    logic [LENGTH_BITS-1:0] r_mbl,    n_mbl;
    logic [BYTE_W-1:0]      r_ebl,    n_ebl;
    logic [1:0]             r_tgt,    n_tgt;
    logic [BYTE_W-1:0]      r_voff,   n_voff;
    logic [1:0]             r_err,    n_err;
    logic                   r_out_valid;
    t_result                r_out,    n_out;

    logic                   accept;
    logic [LENGTH_BITS-1:0] mlen;
    logic [LENGTH_BITS-1:0] after;
    logic [BYTE_W-1:0]      ebl_dec;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign mlen       = LENGTH_BITS'(i_in.message_length);

    always_comb begin
        n_phase = r_phase;
        n_mbl   = r_mbl;
        n_ebl   = r_ebl;
        n_tgt   = r_tgt;
        n_voff  = r_voff;
        n_err   = r_err;
        n_out   = '0;
        ebl_dec = '0;
        n_out.start_of_message = i_in.first_byte;

        if (i_in.first_byte) begin
            n_mbl   = mlen;
            n_phase = PH_TYPE;
            n_ebl   = '0;
            n_tgt   = TGT_NONE;
            n_voff  = '0;
            n_err   = ERR_NONE;
            if (mlen == '0) begin
                n_out.end_of_message = 1'b1;
            end
        end

        after = n_mbl - LENGTH_BITS'(1);

        if (n_mbl != '0) begin
            if (n_err == ERR_NONE) begin
                case (n_phase)
                    PH_TYPE: begin
                        if (n_mbl < LENGTH_BITS'(2)) begin
                            n_err = ERR_BOUNDARY;
                        end else begin
                            if (i_in.data_byte == r_relay_code) begin
                                n_tgt = TGT_RELAY;
                            end else if (i_in.data_byte == r_user_code) begin
                                n_tgt = TGT_USER;
                            end else begin
                                n_tgt = TGT_NONE;
                            end
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if (LENGTH_BITS'(i_in.data_byte) > after) begin
                            n_err = ERR_OVERRUN;
                        end else if (i_in.data_byte == '0) begin
                            n_phase = PH_TYPE;
                        end else begin
                            n_ebl   = i_in.data_byte;
                            n_voff  = '0;
                            n_phase = PH_VALUE;
                        end
                    end
                    PH_VALUE: begin
                        if (n_tgt != TGT_NONE) begin
                            n_out.write_valid  = 1'b1;
                            n_out.field_select = (n_tgt == TGT_USER) ? FIELD_USER
                                                                     : FIELD_RELAY;
                            n_out.field_offset = n_voff;
                            n_out.field_data   = i_in.data_byte;
                        end
                        n_voff  = n_voff + BYTE_W'(1);
                        ebl_dec = n_ebl - BYTE_W'(1);
                        n_ebl   = ebl_dec;
                        if (ebl_dec == '0) begin
                            n_phase = PH_TYPE;
                        end
                    end
                    default: begin
                        n_phase = PH_TYPE;
                    end
                endcase
            end
            n_mbl = after;
            if (after == '0) begin
                n_out.end_of_message = 1'b1;
                n_out.parse_status   = n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay_code <= RELAY_CODE_RST;
            r_user_code  <= USER_CODE_RST;
            r_phase      <= PH_TYPE;
            r_mbl        <= '0;
            r_ebl        <= '0;
            r_tgt        <= TGT_NONE;
            r_voff       <= '0;
            r_err        <= ERR_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RELAY_CODE: r_relay_code <= i_cfg_data;
                    CFG_USER_CODE:  r_user_code  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_phase     <= n_phase;
                r_mbl       <= n_mbl;
                r_ebl       <= n_ebl;
                r_tgt       <= n_tgt;
                r_voff      <= n_voff;
                r_err       <= n_err;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.start_of_message = r_out.start_of_message;
    assign o_out.write_valid      = r_out.write_valid;
    assign o_out.field_select     = r_out.field_select;
    assign o_out.field_offset     = r_out.field_offset;
    assign o_out.field_data       = r_out.field_data;
    assign o_out.end_of_message   = r_out.end_of_message;
    assign o_out.parse_status     = r_out.parse_status;

    `ASSERT_IMPL(a_value_has_bytes, r_phase == PH_VALUE, r_ebl != '0)
    `ASSERT_IMPL(a_elem_within_msg, r_phase == PH_VALUE, LENGTH_BITS'(r_ebl) <= r_mbl)
    `ASSERT_IMPL(a_write_means_ok, r_out_valid && r_out.write_valid,
                 r_out.parse_status == ERR_NONE)
    `ASSERT_NEXT(a_err_holds, accept && !i_in.first_byte && r_err != ERR_NONE,
                 r_err == $past(r_err))

endmodule
